// ===== hw/rtl/lpfd_pkg.sv =====
// shared types and constants of the length-prefixed frame deframer
`timescale 1ns / 1ps

package lpfd_pkg;

  // parser phase
  typedef enum logic [3:0] {
    PH_LWS    = 4'd0,
    PH_LSIGN  = 4'd1,
    PH_LDIG   = 4'd2,
    PH_LTRAIL = 4'd3,
    PH_TYPE   = 4'd4,
    PH_PAY    = 4'd5,
    PH_TCR    = 4'd6,
    PH_TLF    = 4'd7,
    PH_HALT   = 4'd8
  } phase_t;

  // result event codes
  typedef enum logic [2:0] {
    EV_BYTE    = 3'd0,
    EV_OK      = 3'd1,
    EV_BADLEN  = 3'd2,
    EV_BADTYPE = 3'd3,
    EV_BADTERM = 3'd4
  } event_t;

  // message type codes
  localparam logic MT_PB = 1'b0;
  localparam logic MT_JS = 1'b1;

  // characters of the framing
  localparam logic [7:0] CH_CR    = 8'h0D;
  localparam logic [7:0] CH_LF    = 8'h0A;
  localparam logic [7:0] CH_PLUS  = 8'h2B;
  localparam logic [7:0] CH_MINUS = 8'h2D;
  localparam logic [15:0] TYPE_PB = 16'h5042;
  localparam logic [15:0] TYPE_JS = 16'h4A53;

  // one result of the parser
  typedef struct packed {
    logic       valid;
    event_t     ev;
    logic [7:0] data;
    logic       mtype;
    logic       last;
  } result_t;

endpackage

// ===== hw/rtl/lpfd_core.sv =====
// parser state and per-byte update of the deframer
`timescale 1ns / 1ps

module lpfd_core #(
  parameter int LEN_WIDTH = 16
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              step,
  input  logic [7:0]        data,
  input  logic [15:0]       max_len,
  output lpfd_pkg::result_t res
);

  localparam int CW = (LEN_WIDTH > 16) ? LEN_WIDTH : 16;

  // field parsing state, updated together
  typedef struct packed {
    lpfd_pkg::phase_t       phase;
    logic [LEN_WIDTH-1:0]   accum;
    logic                   neg;
    logic                   seen;
    logic                   ovf;
    logic [15:0]            tchars;
    logic [1:0]             tcount;
  } fld_t;

  lpfd_pkg::phase_t     phase, phase_next;
  logic                 cr_pending, cr_pending_next;
  logic [LEN_WIDTH-1:0] length_accum, length_accum_next;
  logic                 length_negative, length_negative_next;
  logic                 digit_seen, digit_seen_next;
  logic                 length_overflow, length_overflow_next;
  logic [15:0]          type_chars, type_chars_next;
  logic [1:0]           type_count, type_count_next;
  logic [15:0]          remaining, remaining_next;
  logic                 frame_type, frame_type_next;

  // one character into the length or type field
  function automatic fld_t feed(input fld_t s, input logic [7:0] c);
    fld_t                 r;
    logic                 dig;
    logic                 ws;
    logic [LEN_WIDTH+3:0] v;
    r   = s;
    dig = c inside {[8'h30:8'h39]};
    ws  = (c == 8'h20) || (c inside {[8'h09:8'h0D]});
    v   = ({4'b0, s.accum} << 3) + ({4'b0, s.accum} << 1)
          + {{LEN_WIDTH{1'b0}}, c[3:0]};
    if (s.phase == lpfd_pkg::PH_TYPE) begin
      r.tchars = {s.tchars[7:0], c};
      if (s.tcount != 2'd3) begin
        r.tcount = s.tcount + 2'd1;
      end
    end else if ((s.phase == lpfd_pkg::PH_LWS && !ws && !dig &&
                  c != lpfd_pkg::CH_PLUS && c != lpfd_pkg::CH_MINUS) ||
                 ((s.phase == lpfd_pkg::PH_LSIGN || s.phase == lpfd_pkg::PH_LDIG)
                  && !dig)) begin
      r.phase = lpfd_pkg::PH_LTRAIL;
    end else if (s.phase == lpfd_pkg::PH_LWS &&
                 (c == lpfd_pkg::CH_PLUS || c == lpfd_pkg::CH_MINUS)) begin
      r.neg   = (c == lpfd_pkg::CH_MINUS);
      r.phase = lpfd_pkg::PH_LSIGN;
    end else if (dig && s.phase != lpfd_pkg::PH_LTRAIL) begin
      // digit accumulation, value frozen once it overflows
      r.seen  = 1'b1;
      r.phase = lpfd_pkg::PH_LDIG;
      if (!s.ovf) begin
        if (v[LEN_WIDTH+3:LEN_WIDTH] != 4'd0) begin
          r.ovf = 1'b1;
        end else begin
          r.accum = v[LEN_WIDTH-1:0];
        end
      end
    end
    return r;
  endfunction

  fld_t           cur, f1, f;
  logic           len_bad;
  logic [CW-1:0]  acc_ext;

  assign cur = '{phase: phase, accum: length_accum, neg: length_negative,
                 seen: digit_seen, ovf: length_overflow, tchars: type_chars,
                 tcount: type_count};
  assign acc_ext = CW'(length_accum);
  assign len_bad = !digit_seen || length_overflow ||
                   (length_negative && length_accum != '0) ||
                   (acc_ext > CW'(max_len));

  // next state and result for the byte in the input register
  always_comb begin
    phase_next           = phase;
    cr_pending_next      = cr_pending;
    length_accum_next    = length_accum;
    length_negative_next = length_negative;
    digit_seen_next      = digit_seen;
    length_overflow_next = length_overflow;
    type_chars_next      = type_chars;
    type_count_next      = type_count;
    remaining_next       = remaining;
    frame_type_next      = frame_type;
    res                  = '0;
    f1                   = feed(cur, lpfd_pkg::CH_CR);
    f                    = cur;
    case (phase)
      lpfd_pkg::PH_PAY: begin
        res.valid = 1'b1;
        res.ev    = lpfd_pkg::EV_BYTE;
        res.data  = data;
        res.mtype = frame_type;
        res.last  = (remaining <= 16'd1);
        if (remaining <= 16'd1) begin
          remaining_next = '0;
          phase_next     = lpfd_pkg::PH_TCR;
        end else begin
          remaining_next = remaining - 16'd1;
        end
      end
      lpfd_pkg::PH_TCR: begin
        if (data == lpfd_pkg::CH_CR) begin
          phase_next = lpfd_pkg::PH_TLF;
        end else begin
          phase_next = lpfd_pkg::PH_HALT;
          res.valid  = 1'b1;
          res.ev     = lpfd_pkg::EV_BADTERM;
          res.mtype  = frame_type;
        end
      end
      lpfd_pkg::PH_TLF: begin
        res.valid = 1'b1;
        res.mtype = frame_type;
        if (data == lpfd_pkg::CH_LF) begin
          // frame closed, back to a fresh length field
          res.ev               = lpfd_pkg::EV_OK;
          phase_next           = lpfd_pkg::PH_LWS;
          cr_pending_next      = 1'b0;
          length_accum_next    = '0;
          length_negative_next = 1'b0;
          digit_seen_next      = 1'b0;
          length_overflow_next = 1'b0;
          type_chars_next      = '0;
          type_count_next      = '0;
          remaining_next       = '0;
        end else begin
          res.ev     = lpfd_pkg::EV_BADTERM;
          phase_next = lpfd_pkg::PH_HALT;
        end
      end
      lpfd_pkg::PH_LWS, lpfd_pkg::PH_LSIGN, lpfd_pkg::PH_LDIG,
      lpfd_pkg::PH_LTRAIL, lpfd_pkg::PH_TYPE: begin
        if (cr_pending && data == lpfd_pkg::CH_LF) begin
          // end of field
          cr_pending_next = 1'b0;
          if (phase == lpfd_pkg::PH_TYPE) begin
            if (type_count == 2'd2 && type_chars == lpfd_pkg::TYPE_PB) begin
              frame_type_next = lpfd_pkg::MT_PB;
              phase_next = (remaining == 16'd0) ? lpfd_pkg::PH_TCR : lpfd_pkg::PH_PAY;
            end else if (type_count == 2'd2 && type_chars == lpfd_pkg::TYPE_JS) begin
              frame_type_next = lpfd_pkg::MT_JS;
              phase_next = (remaining == 16'd0) ? lpfd_pkg::PH_TCR : lpfd_pkg::PH_PAY;
            end else begin
              phase_next = lpfd_pkg::PH_HALT;
              res.valid  = 1'b1;
              res.ev     = lpfd_pkg::EV_BADTYPE;
            end
          end else if (len_bad) begin
            phase_next = lpfd_pkg::PH_HALT;
            res.valid  = 1'b1;
            res.ev     = lpfd_pkg::EV_BADLEN;
          end else begin
            remaining_next  = acc_ext[15:0];
            type_chars_next = '0;
            type_count_next = '0;
            phase_next      = lpfd_pkg::PH_TYPE;
          end
        end else begin
          // ordinary field characters, a held cr counts as one
          if (cr_pending) begin
            if (data == lpfd_pkg::CH_CR) begin
              f = f1;
            end else begin
              cr_pending_next = 1'b0;
              f = feed(f1, data);
            end
          end else if (data == lpfd_pkg::CH_CR) begin
            cr_pending_next = 1'b1;
          end else begin
            f = feed(cur, data);
          end
          phase_next           = f.phase;
          length_accum_next    = f.accum;
          length_negative_next = f.neg;
          digit_seen_next      = f.seen;
          length_overflow_next = f.ovf;
          type_chars_next      = f.tchars;
          type_count_next      = f.tcount;
        end
      end
      default: begin
      end
    endcase
  end

  // state registers
  always_ff @(posedge clk) begin
    if (rst) begin
      phase           <= lpfd_pkg::PH_LWS;
      cr_pending      <= 1'b0;
      length_accum    <= '0;
      length_negative <= 1'b0;
      digit_seen      <= 1'b0;
      length_overflow <= 1'b0;
      type_chars      <= '0;
      type_count      <= '0;
      remaining       <= '0;
      frame_type      <= 1'b0;
    end else if (step) begin
      phase           <= phase_next;
      cr_pending      <= cr_pending_next;
      length_accum    <= length_accum_next;
      length_negative <= length_negative_next;
      digit_seen      <= digit_seen_next;
      length_overflow <= length_overflow_next;
      type_chars      <= type_chars_next;
      type_count      <= type_count_next;
      remaining       <= remaining_next;
      frame_type      <= frame_type_next;
    end
  end

endmodule

// ===== hw/rtl/length_prefixed_frame_deframer.sv =====
// top level of the length-prefixed frame deframer
`timescale 1ns / 1ps

// Takes a byte stream of frames: decimal length, CR LF, type "PB" or "JS",
// CR LF, the payload bytes, CR LF. Bytes come in on in_valid/in_ready with
// data_byte; results leave on out_valid/out_ready with out_event,
// payload_byte, msg_type and payload_last. Each payload byte gives one
// result, a frame-ok or error event closes each frame, framing bytes give
// none.
// One byte is taken per cycle, sustained while the receiver keeps up. A byte is held in an input
// register, parsed by combinational logic and its result, if any, lands in
// the output register, from which it shows on out_valid. While the receiver
// stalls with a result waiting, the input register still takes one more
// byte; after that in_ready falls until the output register drains.
// cfg_we/cfg_wdata write the largest accepted payload length (reset 65535);
// write only while no byte is in flight.
// Reset (rst, synchronous) empties both registers and starts a new length
// field. After any error the block drops every byte with no result until
// the next reset.
module length_prefixed_frame_deframer #(
  parameter int LEN_WIDTH = 16
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_we,
  input  logic [15:0] cfg_wdata,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [7:0]  data_byte,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [2:0]  out_event,
  output logic [7:0]  payload_byte,
  output logic        msg_type,
  output logic        payload_last
);

  logic              max_len_we;
  logic [15:0]       max_len;
  logic              s_valid;
  logic [7:0]        s_byte;
  logic              out_free;
  logic              advance;
  lpfd_pkg::result_t res;

  assign max_len_we = cfg_we;
  assign out_free   = !out_valid || out_ready;
  assign advance    = s_valid && out_free;
  assign in_ready   = !s_valid || advance;

  // configuration register
  always_ff @(posedge clk) begin
    if (rst) begin
      max_len <= 16'hFFFF;
    end else if (max_len_we) begin
      max_len <= cfg_wdata;
    end
  end

  // input register
  always_ff @(posedge clk) begin
    if (rst) begin
      s_valid <= 1'b0;
    end else if (in_valid && in_ready) begin
      s_valid <= 1'b1;
    end else if (advance) begin
      s_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      s_byte <= data_byte;
    end
  end

  lpfd_core #(
    .LEN_WIDTH(LEN_WIDTH)
  ) u_core (
    .clk     (clk),
    .rst     (rst),
    .step    (advance),
    .data    (s_byte),
    .max_len (max_len),
    .res     (res)
  );

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance && res.valid) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && res.valid) begin
      out_event    <= res.ev;
      payload_byte <= res.data;
      msg_type     <= res.mtype;
      payload_last <= res.last;
    end
  end

endmodule

// ===== tb/sv/tb_top.sv =====
// self-checking testbench of the length-prefixed frame deframer
`timescale 1ns / 1ps

module tb_top;

  localparam int QUIET_LIMIT = 1000;
  // margin for a result to pass the input and output registers after its transfer
  localparam int SETTLE_CYCLES = 4;

  typedef struct {
    lpfd_pkg::event_t ev;
    logic [7:0]       data;
    logic             mtype;
    logic             last;
  } deframed_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        cfg_we = 1'b0;
  logic [15:0] cfg_wdata = '0;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic [7:0]  data_byte = '0;
  logic        out_valid;
  logic        out_ready = 1'b1;
  logic [2:0]  out_event;
  logic [7:0]  payload_byte;
  logic        msg_type;
  logic        payload_last;

  int    fails = 0;
  int    bytes_sent = 0;
  int    frames_sent = 0;
  int    results_checked = 0;
  int    settings_written = 0;
  int    quiet_cycles = 0;
  bit    idle_on = 1'b1;
  bit    stall_on = 1'b1;
  string closing_case = "";

  // results still owed by the block, oldest first
  deframed_t   due_events[$];
  // bytes of the frame being assembled
  logic [7:0]  frame_q[$];

  // parser state mirrored from the block
  lpfd_pkg::phase_t ph;
  logic        cr_wait;
  logic [15:0] len_val;
  logic        len_neg;
  logic        len_has_digit;
  logic        len_ovf;
  logic [15:0] type_sr;
  logic [1:0]  type_n;
  logic [15:0] bytes_left;
  logic        cur_type;
  logic [15:0] max_len;

  length_prefixed_frame_deframer #(.LEN_WIDTH(16)) dut (
    .clk         (clk),
    .rst         (rst),
    .cfg_we      (cfg_we),
    .cfg_wdata   (cfg_wdata),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .data_byte   (data_byte),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .out_event   (out_event),
    .payload_byte(payload_byte),
    .msg_type    (msg_type),
    .payload_last(payload_last)
  );

  // clock
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // ---------------------------------------------------------------------------
  // frame parser model

  function automatic void push_result(lpfd_pkg::event_t ev, logic [7:0] d, logic t,
                                      logic l);
    deframed_t r;
    r.ev = ev;
    r.data = d;
    r.mtype = t;
    r.last = l;
    due_events.insert(due_events.size(), r);
  endfunction

  // fresh length field; the frame type survives
  function automatic void clear_length();
    ph = lpfd_pkg::PH_LWS;
    cr_wait = 1'b0;
    len_val = '0;
    len_neg = 1'b0;
    len_has_digit = 1'b0;
    len_ovf = 1'b0;
    type_sr = '0;
    type_n = '0;
    bytes_left = '0;
  endfunction

  function automatic void reset_model();
    max_len = 16'hFFFF;
    cur_type = 1'b0;
    clear_length();
  endfunction

  // decimal accumulate, sticky overflow past 16 bits
  function automatic void take_digit(logic [7:0] c);
    logic [31:0] v;
    len_has_digit = 1'b1;
    if (!len_ovf) begin
      v = 32'(len_val) * 10 + 32'(c) - 32'h30;
      if (v > 32'hFFFF) len_ovf = 1'b1;
      else len_val = v[15:0];
    end
  endfunction

  // one ordinary character of the length or type field
  function automatic void take_field_char(logic [7:0] c);
    bit dig;
    dig = (c >= 8'h30 && c <= 8'h39);
    if (ph == lpfd_pkg::PH_TYPE) begin
      type_sr = {type_sr[7:0], c};
      if (type_n != 2'd3) type_n = type_n + 2'd1;
    end else begin
      case (ph)
        lpfd_pkg::PH_LWS: begin
          if (c == 8'h20 || (c >= 8'h09 && c <= 8'h0D)) begin
            // leading whitespace skipped
          end else if (c == lpfd_pkg::CH_PLUS || c == lpfd_pkg::CH_MINUS) begin
            len_neg = (c == lpfd_pkg::CH_MINUS);
            ph = lpfd_pkg::PH_LSIGN;
          end else if (dig) begin
            take_digit(c);
            ph = lpfd_pkg::PH_LDIG;
          end else begin
            ph = lpfd_pkg::PH_LTRAIL;
          end
        end
        lpfd_pkg::PH_LSIGN, lpfd_pkg::PH_LDIG: begin
          if (dig) begin
            take_digit(c);
            ph = lpfd_pkg::PH_LDIG;
          end else begin
            ph = lpfd_pkg::PH_LTRAIL;
          end
        end
        default: ;
      endcase
    end
  endfunction

  // CR LF seen: judge the field just ended
  function automatic void close_field();
    if (ph == lpfd_pkg::PH_TYPE) begin
      if (type_n == 2'd2 && type_sr == lpfd_pkg::TYPE_PB) begin
        cur_type = lpfd_pkg::MT_PB;
      end else if (type_n == 2'd2 && type_sr == lpfd_pkg::TYPE_JS) begin
        cur_type = lpfd_pkg::MT_JS;
      end else begin
        // type reads zero on type and length errors
        ph = lpfd_pkg::PH_HALT;
        push_result(lpfd_pkg::EV_BADTYPE, 8'h00, 1'b0, 1'b0);
        return;
      end
      ph = (bytes_left == 0) ? lpfd_pkg::PH_TCR : lpfd_pkg::PH_PAY;
    end else if (!len_has_digit || len_ovf || (len_neg && len_val != 0) ||
                 len_val > max_len) begin
      ph = lpfd_pkg::PH_HALT;
      push_result(lpfd_pkg::EV_BADLEN, 8'h00, 1'b0, 1'b0);
    end else begin
      bytes_left = len_val;
      type_sr = '0;
      type_n = '0;
      ph = lpfd_pkg::PH_TYPE;
    end
  endfunction

  // expected results of one transferred byte
  function automatic void deframe_byte(logic [7:0] c);
    logic last;
    case (ph)
      lpfd_pkg::PH_PAY: begin
        last = (bytes_left <= 1);
        push_result(lpfd_pkg::EV_BYTE, c, cur_type, last);
        if (last) begin
          bytes_left = '0;
          ph = lpfd_pkg::PH_TCR;
        end else begin
          bytes_left = bytes_left - 16'd1;
        end
      end
      lpfd_pkg::PH_TCR: begin
        if (c == lpfd_pkg::CH_CR) begin
          ph = lpfd_pkg::PH_TLF;
        end else begin
          ph = lpfd_pkg::PH_HALT;
          push_result(lpfd_pkg::EV_BADTERM, 8'h00, cur_type, 1'b0);
        end
      end
      lpfd_pkg::PH_TLF: begin
        if (c == lpfd_pkg::CH_LF) begin
          push_result(lpfd_pkg::EV_OK, 8'h00, cur_type, 1'b0);
          clear_length();
        end else begin
          ph = lpfd_pkg::PH_HALT;
          push_result(lpfd_pkg::EV_BADTERM, 8'h00, cur_type, 1'b0);
        end
      end
      lpfd_pkg::PH_HALT: ;
      default: begin
        // length and type fields: only CR directly followed by LF ends them
        if (cr_wait) begin
          if (c == lpfd_pkg::CH_LF) begin
            cr_wait = 1'b0;
            close_field();
          end else begin
            take_field_char(lpfd_pkg::CH_CR);
            if (c != lpfd_pkg::CH_CR) begin
              cr_wait = 1'b0;
              take_field_char(c);
            end
          end
        end else if (c == lpfd_pkg::CH_CR) begin
          cr_wait = 1'b1;
        end else begin
          take_field_char(c);
        end
      end
    endcase
  endfunction

  // ---------------------------------------------------------------------------
  // frame assembly

  // append one byte to the frame being assembled
  function automatic void put_byte(logic [7:0] b);
    frame_q.insert(frame_q.size(), b);
  endfunction

  function automatic void put_crlf();
    put_byte(lpfd_pkg::CH_CR);
    put_byte(lpfd_pkg::CH_LF);
  endfunction

  // length text, optionally dressed with whitespace, sign, zeros and trailing text
  function automatic void put_length(int unsigned len, bit fancy);
    logic [7:0]  digs[$];
    logic [7:0]  ch;
    int unsigned n;
    int          start;
    start = frame_q.size();
    if (fancy) begin
      repeat ($urandom_range(0, 2)) begin
        case ($urandom_range(0, 5))
          0: put_byte(8'h20);
          1: put_byte(8'h09);
          2: put_byte(lpfd_pkg::CH_LF);
          3: put_byte(8'h0B);
          4: put_byte(8'h0C);
          default: put_byte(lpfd_pkg::CH_CR);
        endcase
      end
      case ($urandom_range(0, 2))
        1: put_byte(lpfd_pkg::CH_PLUS);
        2: if (len == 0) put_byte(lpfd_pkg::CH_MINUS);
        default: ;
      endcase
      repeat ($urandom_range(0, 2)) put_byte(8'h30);
    end
    n = len;
    do begin
      digs.push_front(8'(32'h30 + n % 10));
      n = n / 10;
    end while (n != 0);
    foreach (digs[i]) put_byte(digs[i]);
    if (fancy && $urandom_range(0, 1) == 1) begin
      ch = 8'($urandom_range(0, 255));
      if (ch >= 8'h30 && ch <= 8'h39) ch = 8'h78;
      put_byte(ch);
      repeat ($urandom_range(0, 2)) put_byte(8'($urandom_range(0, 255)));
    end
    // a CR straight before an LF would end the field early
    for (int i = start; i + 1 < frame_q.size(); i++)
      if (frame_q[i] == lpfd_pkg::CH_CR && frame_q[i + 1] == lpfd_pkg::CH_LF)
        frame_q[i + 1] = 8'h20;
  endfunction

  function automatic void put_frame(int unsigned len, logic mtype, bit fancy);
    logic [15:0] tname;
    tname = (mtype == lpfd_pkg::MT_JS) ? lpfd_pkg::TYPE_JS : lpfd_pkg::TYPE_PB;
    put_length(len, fancy);
    put_crlf();
    put_byte(tname[15:8]);
    put_byte(tname[7:0]);
    put_crlf();
    repeat (len) put_byte(8'($urandom_range(0, 255)));
    put_crlf();
  endfunction

  // ---------------------------------------------------------------------------
  // byte sender and register writes

  task automatic send_byte(logic [7:0] b);
    if (idle_on && $urandom_range(0, 4) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 9)) @(posedge clk);
    end
    in_valid <= 1'b1;
    data_byte <= b;
    do @(posedge clk); while (!in_ready);
    deframe_byte(b);
    bytes_sent++;
  endtask

  task automatic flush_frame();
    while (frame_q.size() != 0) send_byte(frame_q.pop_front());
    frames_sent++;
  endtask

  task automatic send_frame(int unsigned len, logic mtype, bit fancy);
    put_frame(len, mtype, fancy);
    flush_frame();
  endtask

  // write the length limit once every owed result is out and the pipe is empty
  task automatic write_max_len(logic [15:0] v);
    in_valid <= 1'b0;
    while (due_events.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
    cfg_we <= 1'b1;
    cfg_wdata <= v;
    @(posedge clk);
    cfg_we <= 1'b0;
    max_len = v;
    settings_written++;
  endtask

  // ---------------------------------------------------------------------------
  // tests

  task automatic test_basic_frames();
    // empty frame, bare length
    send_frame(0, lpfd_pkg::MT_PB, 1'b0);
    // explicit plus sign, payload at both byte extremes
    put_byte(lpfd_pkg::CH_PLUS);
    put_frame(2, lpfd_pkg::MT_JS, 1'b0);
    frame_q[frame_q.size() - 4] = 8'h00;
    frame_q[frame_q.size() - 3] = 8'hFF;
    flush_frame();
    // minus zero counts as zero
    put_byte(lpfd_pkg::CH_MINUS);
    put_frame(0, lpfd_pkg::MT_PB, 1'b0);
    flush_frame();
  endtask

  task automatic test_length_limits();
    logic [15:0] lim;
    // only empty frames fit
    write_max_len(16'h0000);
    send_frame(0, lpfd_pkg::MT_JS, 1'b1);
    // length right at the limit
    lim = 16'($urandom_range(1, 30));
    write_max_len(lim);
    send_frame(lim, lpfd_pkg::MT_PB, 1'b1);
    write_max_len(16'hFFFF);
    send_frame(20, lpfd_pkg::MT_JS, 1'b1);
  endtask

  task automatic test_random_frames();
    int unsigned len;
    int unsigned top;
    int          n;
    n = 0;
    while (bytes_sent < 950) begin
      // new limit and pacing every few frames
      if (n % 8 == 0) begin
        case ($urandom_range(0, 3))
          0: write_max_len(16'h0000);
          1: write_max_len(16'hFFFF);
          default: write_max_len(16'($urandom_range(1, 80)));
        endcase
        idle_on = ($urandom_range(0, 3) != 0);
        stall_on = ($urandom_range(0, 3) != 0);
      end
      // no idling at all towards the end
      if (bytes_sent >= 850) begin
        idle_on = 1'b0;
        stall_on = 1'b0;
      end
      top = ($urandom_range(0, 7) == 0) ? 150 : 12;
      if (top > max_len) top = max_len;
      len = ($urandom_range(0, 5) == 0) ? top : $urandom_range(0, top);
      send_frame(len,
                 ($urandom_range(0, 1) == 1) ? lpfd_pkg::MT_JS : lpfd_pkg::MT_PB,
                 $urandom_range(0, 3) != 0);
      n++;
    end
  endtask

  // one fatal framing error, then bytes that must be dropped silently
  task automatic test_error_halt();
    int unsigned len;
    logic [7:0]  ch;
    len = $urandom_range(0, (max_len < 5) ? max_len : 5);
    ch = 8'($urandom_range(0, 255));
    case ($urandom_range(0, 6))
      0: begin
        closing_case = "a length field without digits";
        put_byte(8'h20);
        if ($urandom_range(0, 1) == 1) put_byte(8'h71);
        put_crlf();
      end
      1: begin
        closing_case = "a negative length";
        put_byte(lpfd_pkg::CH_MINUS);
        put_length($urandom_range(1, 500), 1'b0);
        put_crlf();
      end
      2: begin
        closing_case = "a length too wide for the counter";
        put_length(65536 + $urandom_range(0, 900000), 1'b1);
        put_crlf();
      end
      3: begin
        closing_case = "a length one over the limit";
        write_max_len(16'($urandom_range(0, 100)));
        put_length(max_len + 1, 1'b1);
        put_crlf();
      end
      4: begin
        closing_case = "a bad type field";
        put_length(len, 1'b1);
        put_crlf();
        case ($urandom_range(0, 2))
          0: put_byte(lpfd_pkg::TYPE_PB[15:8]);
          1: begin
            put_byte(lpfd_pkg::TYPE_JS[15:8]);
            put_byte(lpfd_pkg::TYPE_JS[7:0]);
            put_byte(lpfd_pkg::TYPE_JS[7:0]);
          end
          default: begin
            // lone CR inside the type is a character of it
            put_byte(lpfd_pkg::TYPE_PB[15:8]);
            put_byte(lpfd_pkg::CH_CR);
            put_byte(lpfd_pkg::TYPE_PB[7:0]);
          end
        endcase
        put_crlf();
      end
      5: begin
        closing_case = "a missing closing CR";
        put_frame(len, lpfd_pkg::MT_JS, 1'b1);
        if (ch == lpfd_pkg::CH_CR) ch = 8'h00;
        frame_q[frame_q.size() - 2] = ch;
      end
      default: begin
        closing_case = "a missing closing LF";
        put_frame(len, lpfd_pkg::MT_PB, 1'b1);
        if (ch == lpfd_pkg::CH_LF) ch = 8'h00;
        frame_q[frame_q.size() - 1] = ch;
      end
    endcase
    flush_frame();
    repeat (12) send_byte(8'($urandom_range(0, 255)));
  endtask

  // ---------------------------------------------------------------------------
  // receiver pacing: random stall bursts on out_ready

  initial begin : rx_pacing
    int n;
    forever begin
      @(posedge clk);
      if (stall_on && $urandom_range(0, 4) == 0) begin
        n = $urandom_range(1, 9);
        out_ready <= 1'b0;
        repeat (n) @(posedge clk);
        out_ready <= 1'b1;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // result checking

  function automatic void check_field(string name, logic [7:0] want, logic [7:0] got);
    if (got !== want) begin
      $error("%s mismatch: expected %0d, got %0d", name, want, got);
      fails++;
    end
  endfunction

  always @(posedge clk) begin : result_check
    deframed_t want;
    if (!rst && out_valid && out_ready) begin
      if (due_events.size() == 0) begin
        $error("unexpected result: event %0d, byte %0d", out_event, payload_byte);
        fails++;
      end else begin
        want = due_events.pop_front();
        check_field("out_event", want.ev, out_event);
        check_field("payload_byte", want.data, payload_byte);
        check_field("msg_type", want.mtype, msg_type);
        check_field("payload_last", want.last, payload_last);
        results_checked++;
      end
    end
  end

  // watchdog on cycles with no transfer on either side
  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready)) quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles == QUIET_LIMIT) begin
      $display("timeout: no transfer for %0d cycles", QUIET_LIMIT);
      $display("Some tests failed");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // sequence

  initial begin
    reset_model();
    repeat (6) @(posedge clk);
    rst <= 1'b0;
    test_basic_frames();
    test_length_limits();
    test_random_frames();
    test_error_halt();
    in_valid <= 1'b0;
    while (due_events.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES * 2) @(posedge clk);
    $display("%0d frames, %0d bytes in, %0d results checked, %0d length limits written",
             frames_sent, bytes_sent, results_checked, settings_written);
    $display("stream closed with %s, then ignored bytes after the halt", closing_case);
    if (fails == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
